[rtl/jsfr_pkg.sv]
// ----------------------------------------------------------------------------
// jsfr_pkg: shared types and constants for the JSON object stream framer
// Byte classes, queue entry layout, result status codes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jsfr_pkg;

  // Character codes that steer the framer
  localparam logic [7:0] CHAR_OPEN_BRACE    = 8'h7B; // '{'
  localparam logic [7:0] CHAR_CLOSE_BRACE   = 8'h7D; // '}'
  localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D; // ']'
  localparam logic [7:0] CHAR_QUOTE         = 8'h22; // '"'
  localparam logic [7:0] CHAR_BACKSLASH     = 8'h5C; // '\'

  // Byte classes decided by the front end
  localparam logic [2:0] CLS_OTHER   = 3'd0;
  localparam logic [2:0] CLS_OPEN    = 3'd1;
  localparam logic [2:0] CLS_CLOSE   = 3'd2;
  localparam logic [2:0] CLS_QUOTE   = 3'd3;
  localparam logic [2:0] CLS_BSLASH  = 3'd4;
  localparam logic [2:0] CLS_BRACKET = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ARRAY = 2'd2;
  localparam logic [1:0] ST_EOF   = 2'd3;

  localparam int unsigned CAP_W = 13;

  // One classified item travelling through the queue
  typedef struct packed {
    logic       eof;
    logic [2:0] cls;
    logic [7:0] data;
  } queue_entry_t;

  // Queue occupancy seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Framing state exposed by the back end
  typedef struct packed {
    logic       inside_object;
    logic [7:0] brace_depth;
  } frame_status_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] c;
    case (b)
      CHAR_OPEN_BRACE:    c = CLS_OPEN;
      CHAR_CLOSE_BRACE:   c = CLS_CLOSE;
      CHAR_QUOTE:         c = CLS_QUOTE;
      CHAR_BACKSLASH:     c = CLS_BSLASH;
      CHAR_CLOSE_BRACKET: c = CLS_BRACKET;
      default:            c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/json_object_stream_framer.sv]
// ----------------------------------------------------------------------------
// json_object_stream_framer: splits a JSON byte stream into top-level objects
// An accepted item passes through the queue, then the framing update and the
// result register, which raises out_valid.
// Throughput: one item per cycle while the result side does not stall.
// The two-entry queue takes up back-pressure from the result side.
// Reset (rst, synchronous): queue emptied, framing state cleared to seeking,
// result register empty and buffer capacity back to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_stream_framer import jsfr_pkg::*; #(
  parameter int unsigned MAX_DEPTH        = 255,
  parameter int unsigned MAX_OBJECT_BYTES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_file,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  byte_kept,
  output logic [1:0]            status
);

  // The brace depth is an eight-bit counter, so the limit never exceeds 255.
  localparam logic [7:0] DEPTH_LIMIT =
    (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);
  // The capacity register is 13 bits wide, so any object limit above its
  // largest value leaves the register in charge.
  localparam logic [CAP_W-1:0] CAP_LIMIT =
    (MAX_OBJECT_BYTES > 8191) ? 13'd8191 : CAP_W'(MAX_OBJECT_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;

  queue_status_t q_status;
  queue_entry_t  push_entry;
  queue_entry_t  head;
  frame_status_t frame;
  logic          push;
  logic          pop;

  // The front end classifies each accepted byte and drops it into the queue.
  jsfr_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  // The queue decouples input acceptance from the result side, so a held
  // result does not stop the next item from being taken.
  jsfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // The back end runs the framing state and owns the result register. It
  // takes an item whenever the result register is empty or being emptied.
  jsfr_back #(
    .DEPTH_LIMIT (DEPTH_LIMIT),
    .CAP_LIMIT   (CAP_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_kept (byte_kept),
    .status    (status),
    .frame     (frame)
  );

  // The queue can never be full and empty at once.
  assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // An object is open exactly while the brace depth is non-zero.
  assert property (@(posedge clk) disable iff (rst)
    frame.inside_object == (frame.brace_depth != 8'd0))
    else $error("object flag disagrees with brace depth");

  // An end-of-file item taken from the queue yields an end-of-file result.
  assert property (@(posedge clk) disable iff (rst)
    (pop && head.eof) |=> (out_valid && status == ST_EOF && out_byte == 8'd0
                           && !byte_kept))
    else $error("end of file did not produce its result");

  // After an end-of-file item the framer is back to seeking.
  assert property (@(posedge clk) disable iff (rst)
    (pop && head.eof) |=> (!frame.inside_object))
    else $error("framing state not cleared at end of file");

endmodule

`default_nettype wire

[rtl/jsfr_front.sv]
// ----------------------------------------------------------------------------
// jsfr_front: input acceptance and byte classification
// Accepts items while the queue has room and pushes them in classified form.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfr_front import jsfr_pkg::*; (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_file,
  input  wire queue_status_t q_status,
  output logic               push,
  output queue_entry_t       push_entry
);

  assign in_stall        = q_status.full;
  assign push            = in_valid && !q_status.full;
  // The byte is meaningless on an end-of-file item, so it is classed as other.
  assign push_entry.eof  = end_of_file;
  assign push_entry.cls  = end_of_file ? CLS_OTHER : classify(data_byte);
  assign push_entry.data = data_byte;

endmodule

`default_nettype wire

[rtl/jsfr_queue.sv]
// ----------------------------------------------------------------------------
// jsfr_queue: short flop queue between the front and back ends
// Circular buffer with a fill count; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfr_queue import jsfr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire queue_entry_t push_entry,
  input  wire logic         pop,
  output queue_entry_t      head,
  output queue_status_t     status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  queue_entry_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/jsfr_back.sv]
// ----------------------------------------------------------------------------
// jsfr_back: framing state machine and result register
// Takes classified items from the queue, updates the framing state and
// loads the result register, which holds a result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfr_back import jsfr_pkg::*; #(
  parameter logic [7:0]       DEPTH_LIMIT = 8'd255,
  parameter logic [CAP_W-1:0] CAP_LIMIT   = 13'd4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire queue_entry_t     head,
  input  wire queue_status_t    q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  byte_kept,
  output logic [1:0]            status,
  output frame_status_t         frame
);

  logic [CAP_W-1:0] buffer_capacity;
  logic             inside_object;
  logic [7:0]       brace_depth;
  logic             in_string;
  logic             escape_pending;
  logic [CAP_W-1:0] stored_count;

  logic             inside_object_next;
  logic [7:0]       brace_depth_next;
  logic             in_string_next;
  logic             escape_pending_next;
  logic [CAP_W-1:0] stored_count_next;

  logic             emit;
  logic [7:0]       res_byte;
  logic             res_kept;
  logic [1:0]       res_status;

  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] base_count;
  logic [CAP_W:0]   count_inc;
  logic             fits;
  logic [7:0]       depth_dec;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign frame.inside_object = inside_object;
  assign frame.brace_depth   = brace_depth;

  always_comb begin
    cap = (buffer_capacity > CAP_LIMIT) ? CAP_LIMIT : buffer_capacity;
    // A new object starts its byte count from zero.
    base_count = inside_object ? stored_count : '0;
    count_inc  = {1'b0, base_count} + 1'b1;
    fits       = count_inc < {1'b0, cap};
    depth_dec  = (brace_depth != 8'd0) ? brace_depth - 8'd1 : brace_depth;

    inside_object_next  = inside_object;
    brace_depth_next    = brace_depth;
    in_string_next      = in_string;
    escape_pending_next = escape_pending;
    stored_count_next   = stored_count;
    emit       = 1'b0;
    res_byte   = head.data;
    res_kept   = fits;
    res_status = ST_BYTE;

    if (head.eof) begin
      inside_object_next  = 1'b0;
      brace_depth_next    = 8'd0;
      in_string_next      = 1'b0;
      escape_pending_next = 1'b0;
      stored_count_next   = '0;
      emit       = 1'b1;
      res_byte   = 8'd0;
      res_kept   = 1'b0;
      res_status = ST_EOF;
    end else if (!inside_object) begin
      if (head.cls == CLS_OPEN) begin
        inside_object_next  = 1'b1;
        brace_depth_next    = 8'd1;
        in_string_next      = 1'b0;
        escape_pending_next = 1'b0;
        stored_count_next   = fits ? count_inc[CAP_W-1:0] : '0;
        emit = 1'b1;
      end else if (head.cls == CLS_BRACKET) begin
        emit       = 1'b1;
        res_kept   = 1'b0;
        res_status = ST_ARRAY;
      end
    end else begin
      emit = 1'b1;
      if (fits) begin
        stored_count_next = count_inc[CAP_W-1:0];
      end
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (in_string) begin
        if (head.cls == CLS_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (head.cls == CLS_QUOTE) begin
          in_string_next = 1'b0;
        end
      end else begin
        case (head.cls)
          CLS_QUOTE: begin
            in_string_next = 1'b1;
          end
          CLS_OPEN: begin
            if (brace_depth < DEPTH_LIMIT) begin
              brace_depth_next = brace_depth + 8'd1;
            end
          end
          CLS_CLOSE: begin
            if (depth_dec == 8'd0) begin
              inside_object_next  = 1'b0;
              brace_depth_next    = 8'd0;
              in_string_next      = 1'b0;
              escape_pending_next = 1'b0;
              stored_count_next   = '0;
              res_status          = ST_DONE;
            end else begin
              brace_depth_next = depth_dec;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= 13'd4096;
      inside_object   <= 1'b0;
      brace_depth     <= 8'd0;
      in_string       <= 1'b0;
      escape_pending  <= 1'b0;
      stored_count    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_capacity <= cfg_wdata;
      end
      if (pop) begin
        inside_object  <= inside_object_next;
        brace_depth    <= brace_depth_next;
        in_string      <= in_string_next;
        escape_pending <= escape_pending_next;
        stored_count   <= stored_count_next;
        out_valid      <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte  <= res_byte;
      byte_kept <= res_kept;
      status    <= res_status;
    end
  end

endmodule

`default_nettype wire

[test/json_object_stream_framer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_object_stream_framer_tb: self-checking bench for the JSON object framer
// Feeds directed rows, a deeply nested over-long object and random JSON-like
// streams under several buffer capacities, with random idling on both sides.
// Every result item is checked against its typed row or a predictor held in the bench.
// ----------------------------------------------------------------------------

module json_object_stream_framer_tb import jsfr_pkg::*; ();

  localparam int unsigned FR_MAX_DEPTH   = 255;
  localparam int unsigned FR_MAX_OBJECT  = 4096;
  localparam int          RESULT_LATENCY = 2;
  localparam int          IDLE_PCT       = 31;
  localparam int          STALL_LIMIT    = 2000;
  localparam int          PHASE_RESULTS  = 50;
  localparam int          N_PHASES       = 8;
  localparam int          N_ROWS         = 21;

  // One result item as the block presents it.
  typedef struct packed {
    logic [7:0] b;
    logic       kept;
    logic [1:0] st;
  } framed_byte_t;

  // One row of the directed table. Where typed is set, want holds the result
  // item read straight off the rules; otherwise the predictor decides.
  typedef struct packed {
    logic         eof;
    logic [7:0]   b;
    logic         typed;
    framed_byte_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             end_of_file = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             byte_kept;
  logic [1:0]       status;

  json_object_stream_framer #(
    .MAX_DEPTH       (FR_MAX_DEPTH),
    .MAX_OBJECT_BYTES(FR_MAX_OBJECT)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_kept  (byte_kept),
    .status     (status)
  );

  always #5 clk = ~clk;

  // Framing state of the predictor.
  logic             pr_inside;
  logic [7:0]       pr_depth;
  logic             pr_in_string;
  logic             pr_escape;
  logic [CAP_W-1:0] pr_stored;
  logic [CAP_W-1:0] buf_capacity;

  framed_byte_t expected_bytes[$];
  framed_byte_t mon_want;
  int           mismatches = 0;
  int           results_sent = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;

  stim_row_t        directed_rows[N_ROWS];
  logic [CAP_W-1:0] phase_caps[N_PHASES];

  function automatic void clear_frame();
    pr_inside    = 1'b0;
    pr_depth     = '0;
    pr_in_string = 1'b0;
    pr_escape    = 1'b0;
    pr_stored    = '0;
  endfunction

  // A byte is kept while there is room for it and the terminator.
  function automatic logic store_byte();
    int unsigned cap;
    cap = (buf_capacity > FR_MAX_OBJECT) ? FR_MAX_OBJECT : buf_capacity;
    if (int'(pr_stored) + 1 < cap) begin
      pr_stored = pr_stored + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predictor by one input item; returns 1 when it yields a result.
  function automatic bit frame_byte(input logic [7:0] b, input logic e,
                                    output framed_byte_t r);
    int unsigned depth_cap;
    depth_cap = (FR_MAX_DEPTH > 255) ? 255 : FR_MAX_DEPTH;
    r = '0;
    if (e) begin
      clear_frame();
      r.st = ST_EOF;
      return 1'b1;
    end
    if (!pr_inside) begin
      if (b == CHAR_OPEN_BRACE) begin
        clear_frame();
        pr_inside = 1'b1;
        pr_depth  = 8'd1;
        r.b    = b;
        r.kept = store_byte();
        r.st   = ST_BYTE;
        return 1'b1;
      end
      if (b == CHAR_CLOSE_BRACKET) begin
        r.b  = b;
        r.st = ST_ARRAY;
        return 1'b1;
      end
      return 1'b0;
    end
    r.b    = b;
    r.kept = store_byte();
    r.st   = ST_BYTE;
    if (pr_escape) begin
      pr_escape = 1'b0;
    end else if (pr_in_string) begin
      if (b == CHAR_BACKSLASH) begin
        pr_escape = 1'b1;
      end else if (b == CHAR_QUOTE) begin
        pr_in_string = 1'b0;
      end
    end else if (b == CHAR_QUOTE) begin
      pr_in_string = 1'b1;
    end else if (b == CHAR_OPEN_BRACE) begin
      if (pr_depth < depth_cap) pr_depth = pr_depth + 1'b1;
    end else if (b == CHAR_CLOSE_BRACE) begin
      if (pr_depth > 0) pr_depth = pr_depth - 1'b1;
      if (pr_depth == 0) begin
        clear_frame();
        r.st = ST_DONE;
      end
    end
    return 1'b1;
  endfunction

  // Any byte that does not steer the framer.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (classify(c) != CLS_OTHER) c = 8'h61;
    return c;
  endfunction

  // Any byte at all.
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one input item, idling at random first, and records the expected
  // result once the item has been accepted. The item is accepted at the edge
  // that follows a falling edge at which in_stall was seen low.
  task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
                           input framed_byte_t want);
    bit           stalled;
    bit           got;
    framed_byte_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= e;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    got = frame_byte(b, e, r);
    if (typed) begin
      expected_bytes.push_back(want);
    end else if (got) begin
      expected_bytes.push_back(r);
    end
    if (got) results_sent++;
  endtask

  task automatic send(input logic [7:0] b, input logic e);
    send_item(b, e, 1'b0, '0);
  endtask

  // Waits until the block is idle and then writes the capacity register.
  task automatic set_capacity(input logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_capacity = v;
  endtask

  // One JSON-like object with random nesting, strings and escapes. Now and
  // then it is cut off by end of file, and noise follows it.
  task automatic gen_object();
    int nest;
    int len;
    int m;
    send(CHAR_OPEN_BRACE, 1'b0);
    nest = 1;
    len  = $urandom_range(1, 30);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (nest < 6) begin
            send(CHAR_OPEN_BRACE, 1'b0);
            nest++;
          end else begin
            send(plain_byte(), 1'b0);
          end
        end
        2: begin
          if (nest > 1) begin
            send(CHAR_CLOSE_BRACE, 1'b0);
            nest--;
          end else begin
            send(plain_byte(), 1'b0);
          end
        end
        3, 4: begin
          send(CHAR_QUOTE, 1'b0);
          m = $urandom_range(0, 6);
          for (int j = 0; j < m; j++) begin
            if ($urandom_range(0, 4) == 0) begin
              // The escaped byte may be anything, a quote or backslash too.
              send(CHAR_BACKSLASH, 1'b0);
              send(any_byte(), 1'b0);
            end else begin
              send(plain_byte(), 1'b0);
            end
          end
          send(CHAR_QUOTE, 1'b0);
        end
        9: send(any_byte(), 1'b0);
        default: send(plain_byte(), 1'b0);
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      send(any_byte(), 1'b1);
    end else begin
      repeat (nest) send(CHAR_CLOSE_BRACE, 1'b0);
    end
    repeat ($urandom_range(0, 3)) send(any_byte(), 1'b0);
    if ($urandom_range(0, 7) == 0) send(CHAR_CLOSE_BRACKET, 1'b0);
    if ($urandom_range(0, 19) == 0) send(any_byte(), 1'b1);
  endtask

  // Result side stalls at random except in the calm phase.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Checks result items and watches for a hung run. Outputs and stalls are
  // stable from the falling edge up to the rising edge that takes the item.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result: byte %h kept %b status %0d",
                 $time, out_byte, byte_kept, status);
        mismatches++;
      end else begin
        mon_want = expected_bytes.pop_front();
        if (out_byte !== mon_want.b) begin
          $display("%0t: out_byte expected %h actual %h", $time, mon_want.b, out_byte);
          mismatches++;
        end
        if (byte_kept !== mon_want.kept) begin
          $display("%0t: byte_kept expected %b actual %b", $time, mon_want.kept,
                   byte_kept);
          mismatches++;
        end
        if (status !== mon_want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, mon_want.st, status);
          mismatches++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("json_object_stream_framer_tb failed");
      $finish;
    end
  end

  initial begin
    clear_frame();
    buf_capacity = 13'd4096;

    // eof, byte, typed, expected byte, kept, status
    directed_rows = '{
      {1'b0, CHAR_CLOSE_BRACKET, 1'b1, CHAR_CLOSE_BRACKET, 1'b0, ST_ARRAY},
      {1'b0, 8'h78,              1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b1, 8'hFF,              1'b1, 8'h00,              1'b0, ST_EOF},
      {1'b0, CHAR_OPEN_BRACE,    1'b1, CHAR_OPEN_BRACE,    1'b1, ST_BYTE},
      {1'b0, CHAR_QUOTE,         1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_BACKSLASH,     1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_QUOTE,         1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_CLOSE_BRACE,   1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_QUOTE,         1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_OPEN_BRACE,    1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, 8'h00,              1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, 8'hFF,              1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_CLOSE_BRACKET, 1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_CLOSE_BRACE,   1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, CHAR_CLOSE_BRACE,   1'b1, CHAR_CLOSE_BRACE,   1'b1, ST_DONE},
      {1'b0, CHAR_OPEN_BRACE,    1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, 8'h61,              1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b1, 8'h00,              1'b1, 8'h00,              1'b0, ST_EOF},
      {1'b0, CHAR_CLOSE_BRACE,   1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b0, 8'h80,              1'b0, 8'h00,              1'b0, ST_BYTE},
      {1'b1, 8'h55,              1'b1, 8'h00,              1'b0, ST_EOF}
    };

    // Zero, one and the largest register value are among the settings.
    phase_caps = '{13'd1, 13'd0, 13'd2, 13'd5, 13'd4096, 13'h1FFF, 13'd7, 13'd4096};
    phase_caps[3] = CAP_W'($urandom_range(3, 40));
    phase_caps[6] = CAP_W'($urandom_range(1, 8191));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, run at the capacity left by reset.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].b, directed_rows[i].eof, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // An object nested past the depth limit and longer than a 300-byte
    // buffer can hold. The depth saturates, so the object ends before its
    // last closing braces.
    set_capacity(13'd300);
    repeat (258) send(CHAR_OPEN_BRACE, 1'b0);
    repeat (50) send(plain_byte(), 1'b0);
    repeat (258) send(CHAR_CLOSE_BRACE, 1'b0);

    // Random phases. Each capacity change falls inside an open object, so the
    // new value governs the bytes that follow it.
    for (int p = 0; p < N_PHASES; p++) begin
      int target;
      send(CHAR_OPEN_BRACE, 1'b0);
      send(plain_byte(), 1'b0);
      set_capacity(phase_caps[p]);
      calm = (p == 3);
      send(plain_byte(), 1'b0);
      send(CHAR_CLOSE_BRACE, 1'b0);
      target = results_sent + PHASE_RESULTS;
      while (results_sent < target) gen_object();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 6) @(posedge clk);
    if (mismatches == 0) begin
      $display("json_object_stream_framer_tb passed");
    end else begin
      $display("json_object_stream_framer_tb failed");
    end
    $finish;
  end

endmodule
